// ===== design/pra_pkg.sv =====
// Shared constants, types and helpers for the particle render attribute pipeline.
package pra_pkg;
  localparam int FracBits = 16;
  localparam int TW       = FracBits + 1;
  localparam int DivBits  = FracBits;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] age_now;
    logic signed [31:0] life_span;
    logic signed [31:0] size_begin;
    logic signed [31:0] size_finish;
    logic [7:0]         alpha_begin;
    logic [7:0]         alpha_finish;
  } item_t;

  typedef struct packed {
    logic signed [16:0] dest_x;
    logic signed [16:0] dest_y;
    logic [15:0]        dest_size;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } result_t;

  // Channel value: frac in 0..2^F (2^F is one), times 255, back to 8 bits.
  function automatic logic [7:0] chan(input logic [FracBits:0] frac);
    logic [FracBits+8:0] p;
    p = {8'd0, frac} * (FracBits+9)'(255);
    return p[FracBits+7:FracBits];
  endfunction

  // Truncate Q value toward zero, then subtract half, saturate to 17 bits.
  function automatic logic signed [16:0] edge_of(input logic signed [31:0] q,
                                                 input logic [14:0] half);
    logic [31:0]        mag;
    logic signed [33:0] ti;
    logic signed [33:0] e;
    mag = q[31] ? 32'(-q) : 32'(q);
    ti  = q[31] ? -$signed({2'b0, mag >> FracBits}) : $signed({2'b0, mag >> FracBits});
    e   = ti - $signed({19'd0, half});
    if (e < -34'sd65536) return -17'sd65536;
    else if (e > 34'sd65535) return 17'sd65535;
    else return e[16:0];
  endfunction
endpackage

// ===== design/particle_render_attributes.sv =====
// Top level of the particle render attribute pipeline.
// Each transaction carries one particle and yields exactly one result transaction.
// The block takes one particle every cycle unless the output is stalled. The result
// reaches out_tvalid through the life-fraction divider, an input register followed
// by one quotient bit per stage (17 stages in all), then three stages for size, hue,
// and alpha and the output register. While out_tvalid is high and out_tready is low,
// the whole pipeline holds its contents; in_tready follows out_tready, with the
// output register reloading when it is empty. The hue wheel splits t*6 into a
// sector and a fraction. Size is interpolated exactly with 32 fraction bits over a
// multiply stage and a sum stage. Alpha uses t cubed, formed by two registered
// 17x17 multiplies.
module particle_render_attributes (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, age_now, life_span, size_begin, size_finish, alpha_begin, alpha_finish
  input  logic [207:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // dest_x, dest_y, dest_size, red, green, blue, alpha (pad to 88 bits)
  output logic [87:0]  out_tdata
);
  import pra_pkg::*;

  item_t it;
  logic  en;
  assign it.pos_x        = in_tdata[31:0];
  assign it.pos_y        = in_tdata[63:32];
  assign it.age_now      = in_tdata[95:64];
  assign it.life_span    = in_tdata[127:96];
  assign it.size_begin   = in_tdata[159:128];
  assign it.size_finish  = in_tdata[191:160];
  assign it.alpha_begin  = in_tdata[199:192];
  assign it.alpha_finish = in_tdata[207:200];

  // Advance whenever the output slot is free or being drained.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic f_one, f_zero;
  assign f_one  = (it.life_span <= 0) || (it.age_now >= it.life_span);
  assign f_zero = !f_one && (it.age_now <= 0);

  logic            d_vld;
  logic [TW-1:0]   d_t;
  item_t           d_item;
  pra_div u_div (
    .clk, .rst_n, .en,
    .in_vld(in_tvalid), .num(it.age_now[30:0]), .den(it.life_span[30:0]),
    .force_one(f_one), .force_zero(f_zero), .in_item(it),
    .out_vld(d_vld), .t_out(d_t), .out_item(d_item)
  );

  // Stage A: t*t, size delta multiply, hue split.
  logic               a_vld_r;
  item_t              a_item_r;
  logic [TW-1:0]      a_t_r;
  logic [2*TW-1:0]    a_tt_r;
  logic signed [51:0] a_dt_r;
  logic [2:0]         a_sec_r;
  logic [FracBits-1:0] a_f_r;
  // Stage B: t2*t, size sum, hue channels.
  logic               b_vld_r;
  item_t              b_item_r;
  logic [2*TW-1:0]    b_t3p_r;
  logic signed [51:0] b_sz_r;
  logic [7:0]         b_r_r, b_g_r, b_b_r;
  // Stage C: diff * t3, size rounding.
  logic               c_vld_r;
  item_t              c_item_r;
  logic [7:0]         c_r_r, c_g_r, c_b_r;
  logic [15:0]        c_ds_r;
  logic [FracBits+8:0] c_dp_r;
  logic               c_neg_r;
  // Stage D: final edges and alpha, output register.
  result_t            o_r;
  logic               o_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0; b_vld_r <= 1'b0; c_vld_r <= 1'b0; o_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= d_vld; b_vld_r <= a_vld_r; c_vld_r <= b_vld_r; o_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      logic [TW+2:0]       h;
      logic [2:0]          s;
      logic [TW-1:0]       t2;
      logic [TW-1:0]       t3;
      logic [FracBits:0]   q;
      logic signed [32:0]  sdiff;
      logic signed [8:0]   adiff;
      logic [7:0]          amag;
      logic [14:0]         half;
      logic signed [9:0]   av;
      // stage A
      a_item_r <= d_item;
      a_t_r    <= d_t;
      a_tt_r   <= d_t * d_t;
      sdiff    = 33'(d_item.size_finish) - 33'(d_item.size_begin);
      a_dt_r   <= 52'(sdiff) * $signed({35'd0, d_t});
      h        = (TW+3)'(d_t) * (TW+3)'(6);
      s        = h[FracBits+2:FracBits];
      a_sec_r  <= (s == 3'd6) ? 3'd0 : s;
      a_f_r    <= h[FracBits-1:0];
      // stage B
      b_item_r <= a_item_r;
      t2       = a_tt_r[FracBits+TW-1:FracBits];
      b_t3p_r  <= t2 * a_t_r;
      b_sz_r   <= ($signed(52'(a_item_r.size_begin)) <<< FracBits) + a_dt_r;
      // one minus the fraction reaches one itself when the fraction is zero
      q        = (TW'(1) << FracBits) - TW'(a_f_r);
      case (a_sec_r)
        3'd0:    begin b_r_r <= 8'd255; b_g_r <= chan({1'b0, a_f_r}); b_b_r <= 8'd0; end
        3'd1:    begin b_r_r <= chan(q); b_g_r <= 8'd255; b_b_r <= 8'd0; end
        3'd2:    begin b_r_r <= 8'd0; b_g_r <= 8'd255; b_b_r <= chan({1'b0, a_f_r}); end
        3'd3:    begin b_r_r <= 8'd0; b_g_r <= chan(q); b_b_r <= 8'd255; end
        3'd4:    begin b_r_r <= chan({1'b0, a_f_r}); b_g_r <= 8'd0; b_b_r <= 8'd255; end
        default: begin b_r_r <= 8'd255; b_g_r <= 8'd0; b_b_r <= chan(q); end
      endcase
      // stage C
      c_item_r <= b_item_r;
      c_r_r <= b_r_r; c_g_r <= b_g_r; c_b_r <= b_b_r;
      if (b_sz_r <= 0) c_ds_r <= '0;
      else begin
        logic [51:0] rs;
        rs = 52'(b_sz_r) + (52'd1 << (2*FracBits-1));
        c_ds_r <= (rs[51:2*FracBits] > 20'd65535) ? 16'hFFFF : rs[2*FracBits+15:2*FracBits];
      end
      t3      = b_t3p_r[FracBits+TW-1:FracBits];
      adiff   = $signed({1'b0, b_item_r.alpha_finish}) - $signed({1'b0, b_item_r.alpha_begin});
      c_neg_r <= adiff[8];
      amag    = adiff[8] ? 8'(-adiff) : adiff[7:0];
      c_dp_r  <= amag * t3;
      // stage D
      half       = c_ds_r[15:1];
      o_r.dest_x    <= edge_of(c_item_r.pos_x, half);
      o_r.dest_y    <= edge_of(c_item_r.pos_y, half);
      o_r.dest_size <= c_ds_r;
      o_r.red <= c_r_r; o_r.green <= c_g_r; o_r.blue <= c_b_r;
      av = c_neg_r ? 10'($signed({2'b0, c_item_r.alpha_begin})) - 10'(c_dp_r[FracBits+8:FracBits])
                   : 10'($signed({2'b0, c_item_r.alpha_begin})) + 10'(c_dp_r[FracBits+8:FracBits]);
      o_r.alpha <= (av < 0) ? 8'd0 : (av > 10'sd255) ? 8'd255 : av[7:0];
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = {6'd0, o_r.alpha, o_r.blue, o_r.green, o_r.red,
                       o_r.dest_size, o_r.dest_y, o_r.dest_x};
endmodule

// ===== design/pra_div.sv =====
// Pipelined restoring divider giving the life fraction t, one quotient bit per stage.
module pra_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [30:0]          num,     // age, 0 < age < life
  input  logic [30:0]          den,     // life
  input  logic                 force_one,
  input  logic                 force_zero,
  input  pra_pkg::item_t       in_item,
  output logic                 out_vld,
  output logic [pra_pkg::TW-1:0] t_out,
  output pra_pkg::item_t       out_item
);
  import pra_pkg::*;
  localparam int N = DivBits;

  logic [N:0]         vld_r;
  logic [31:0]        rem_r   [N+1];
  logic [30:0]        den_r   [N+1];
  logic [N-1:0]       q_r     [N+1];
  logic [1:0]         frc_r   [N+1];
  item_t              item_r  [N+1];

  // Stage 0 holds remainder = age (integer part of age*2^F / life is zero
  // since age < life); each stage shifts in one zero fraction bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= {1'b0, num};
      den_r[0]  <= den;
      q_r[0]    <= '0;
      frc_r[0]  <= {force_one, force_zero};
      item_r[0] <= in_item;
      for (int i = 0; i < N; i++) begin
        logic [32:0] sh;
        logic [32:0] df;
        sh = {rem_r[i], 1'b0};
        df = sh - {2'b0, den_r[i]};
        if (!df[32]) begin
          rem_r[i+1] <= df[31:0];
          q_r[i+1]   <= {q_r[i][N-2:0], 1'b1};
        end else begin
          rem_r[i+1] <= sh[31:0];
          q_r[i+1]   <= {q_r[i][N-2:0], 1'b0};
        end
        den_r[i+1]  <= den_r[i];
        frc_r[i+1]  <= frc_r[i];
        item_r[i+1] <= item_r[i];
      end
    end
  end

  assign out_vld  = vld_r[N];
  assign out_item = item_r[N];
  always_comb begin
    if (frc_r[N][1])      t_out = TW'(1) << FracBits;
    else if (frc_r[N][0]) t_out = '0;
    else                  t_out = {1'b0, q_r[N]};
  end
endmodule
